// ===== rtl/b64sc_pkg.sv =====
// Shared types, constants and character tables for the base64 stream codec.
// No dependencies; every other file refers to this package by scoped names.
package b64sc_pkg;

	// Width of the internal message byte counter, saturating.
	localparam int COUNT_WIDTH = 16;
	localparam logic [15:0] CNT_LIM = (COUNT_WIDTH >= 16) ? 16'hFFFF
		: 16'((32'd1 << COUNT_WIDTH) - 32'd1);

	// Depth of the queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Result slots per queue entry: three data slots, each with CR and LF, then status.
	localparam int NDATA = 3;
	localparam int NSLOT = 3 * NDATA + 1;

	// Register indexes of the configuration port.
	localparam logic REG_MODE        = 1'b0;
	localparam logic REG_LINE_LENGTH = 1'b1;

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	localparam logic [7:0] LINE_LENGTH_RST = 8'd76;

	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [6:0] CHAR_PAD = 7'h3D;

	// Digit codes beyond the 64 legal values.
	localparam logic [6:0] DIG_PAD = 7'd64;
	localparam logic [6:0] DIG_BAD = 7'd65;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		kind_t       kind;
		logic [15:0] count;
		logic        run_end;
	} out_item_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] line_length;
	} cfg_t;

	// One queue entry: the results that one input item causes.
	typedef struct packed {
		logic [NDATA-1:0]       dv;
		logic [NDATA-1:0][7:0]  db;
		logic [NDATA-1:0]       brk;
		logic                   st_v;
		kind_t                  st_kind;
		logic [15:0]            st_count;
	} rec_t;

	// Map a 6-bit group to its alphabet character.
	function automatic logic [7:0] b64_char(input logic [5:0] six);
		logic [7:0] c;
		case (six) inside
			[6'd0:6'd25]:  c = 8'h41 + 8'(six);
			[6'd26:6'd51]: c = 8'h61 + 8'(six - 6'd26);
			[6'd52:6'd61]: c = 8'h30 + 8'(six - 6'd52);
			6'd62:         c = 8'h2B;
			default:       c = 8'h2F;
		endcase
		return c;
	endfunction

	// Map a 7-bit character to its digit, DIG_PAD for '=', DIG_BAD otherwise.
	function automatic logic [6:0] b64_digit(input logic [6:0] c);
		logic [6:0] d;
		case (c) inside
			[7'h41:7'h5A]: d = c - 7'h41;
			[7'h61:7'h7A]: d = c - 7'h61 + 7'd26;
			[7'h30:7'h39]: d = c - 7'h30 + 7'd52;
			7'h2B:         d = 7'd62;
			7'h2F:         d = 7'd63;
			CHAR_PAD:      d = DIG_PAD;
			default:       d = DIG_BAD;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/b64sc_front.sv =====
// Front end of the base64 codec: accepts items, updates message state and
// builds one queue entry per item that causes results. Uses b64sc_pkg.
module b64sc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  b64sc_pkg::cfg_t     cfg,
	input  logic                push,
	input  b64sc_pkg::in_item_t item,
	input  logic                q_full,
	output logic                q_wr,
	output b64sc_pkg::rec_t     rec
);

	logic [15:0] bs_q;
	logic [2:0]  held_q;
	logic [7:0]  lp_q;
	logic [15:0] tot_q;
	logic        disc_q;

	logic [15:0] bs_d;
	logic [2:0]  held_d;
	logic [7:0]  lp_d;
	logic [15:0] tot_d;
	logic        disc_d;

	logic        accept;
	logic [7:0]  b;
	logic        lst;

	// encode path
	logic [15:0] bs_enc;
	logic [3:0]  h_enc;
	logic [3:0]  r1;
	logic [3:0]  r2;
	logic        two;
	logic        flush;
	logic [5:0]  c0;
	logic [5:0]  c1;
	logic [5:0]  cf;
	logic [b64sc_pkg::NDATA-1:0][5:0] six;
	logic [b64sc_pkg::NDATA-1:0]      cv;
	logic [b64sc_pkg::NDATA-1:0]      brk;
	logic [7:0]  lp_w;
	logic [7:0]  p;

	// decode path
	logic        is_crlf;
	logic [6:0]  dig;
	logic [15:0] bs_dec;
	logic [3:0]  h_dec;

	logic [3:0]  ndata;
	logic [16:0] sum;
	logic [15:0] tot_new;
	logic        err;

	assign accept = push && !q_full;
	assign b      = item.in_byte;
	assign lst    = item.last;

	// Split the encode bit store into up to three characters
	always_comb begin
		bs_enc = {bs_q[7:0], b};
		h_enc  = {1'b0, held_q} + 4'd8;
		r1     = h_enc - 4'd6;
		two    = r1 >= 4'd6;
		r2     = two ? (r1 - 4'd6) : r1;
		flush  = lst && (r2 != 4'd0);
		c0     = 6'(bs_enc >> r1);
		c1     = 6'(bs_enc >> (r1 - 4'd6));
		cf     = 6'(bs_enc << (4'd6 - r2));
		six[0] = c0;
		six[1] = two ? c1 : cf;
		six[2] = cf;
		cv[0]  = 1'b1;
		cv[1]  = two || flush;
		cv[2]  = two && flush;
	end

	// Walk the line position over the characters of this item
	always_comb begin
		lp_w = lp_q;
		p    = '0;
		brk  = '0;
		for (int k = 0; k < b64sc_pkg::NDATA; k++) begin
			p = lp_w + 8'd1;
			if (cv[k]) begin
				brk[k] = (cfg.line_length != 8'd0) && (p == cfg.line_length);
				lp_w   = brk[k] ? 8'd0 : p;
			end
		end
	end

	// Decode one character
	always_comb begin
		is_crlf = (b == b64sc_pkg::CHAR_CR) || (b == b64sc_pkg::CHAR_LF);
		dig     = b64sc_pkg::b64_digit(b[6:0]);
		bs_dec  = {bs_q[9:0], dig[5:0]};
		h_dec   = {1'b0, held_q} + 4'd6;
	end

	// Build the queue entry and the next message state
	always_comb begin
		rec    = '0;
		bs_d   = bs_q;
		held_d = held_q;
		lp_d   = lp_q;
		disc_d = disc_q;
		ndata  = '0;
		err    = 1'b0;
		if (disc_q) begin
			// drop input through the last-marked item
		end else if (cfg.mode == b64sc_pkg::MODE_ENCODE) begin
			bs_d   = bs_enc;
			held_d = r2[2:0];
			lp_d   = lp_w;
			for (int k = 0; k < b64sc_pkg::NDATA; k++) begin
				rec.dv[k]  = cv[k];
				rec.db[k]  = b64sc_pkg::b64_char(six[k]);
				rec.brk[k] = brk[k];
				ndata      = ndata + (cv[k] ? 4'd1 : 4'd0) + (brk[k] ? 4'd2 : 4'd0);
			end
		end else if (!is_crlf) begin
			if (dig == b64sc_pkg::DIG_BAD) begin
				err          = 1'b1;
				rec.st_v     = 1'b1;
				rec.st_kind  = b64sc_pkg::KIND_ERR;
				disc_d       = !lst;
			end else if (dig != b64sc_pkg::DIG_PAD) begin
				bs_d = bs_dec;
				if (h_dec >= 4'd8) begin
					rec.dv[0] = 1'b1;
					rec.db[0] = 8'(bs_dec >> (h_dec - 4'd8));
					held_d    = 3'(h_dec - 4'd8);
					ndata     = 4'd1;
				end else begin
					held_d = h_dec[2:0];
				end
			end
		end

		sum     = {1'b0, tot_q} + 17'(ndata);
		tot_new = (sum > {1'b0, b64sc_pkg::CNT_LIM}) ? b64sc_pkg::CNT_LIM : sum[15:0];
		tot_d   = disc_q ? tot_q : tot_new;

		if (disc_q) begin
			if (lst) begin
				disc_d = 1'b0;
			end
		end else if (lst && !err) begin
			rec.st_v     = 1'b1;
			rec.st_kind  = b64sc_pkg::KIND_END;
			rec.st_count = tot_new;
		end

		// clear the message state once the message is over
		if (lst) begin
			bs_d   = '0;
			held_d = '0;
			lp_d   = '0;
			tot_d  = '0;
		end
	end

	assign q_wr = accept && ((|rec.dv) || rec.st_v);

	// Advance message state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= '0;
			held_q <= '0;
			lp_q   <= '0;
			tot_q  <= '0;
			disc_q <= 1'b0;
		end else if (accept) begin
			bs_q   <= bs_d;
			held_q <= held_d;
			lp_q   <= lp_d;
			tot_q  <= tot_d;
			disc_q <= disc_d;
		end
	end

endmodule

// ===== rtl/b64sc_queue.sv =====
// Short queue of result entries between the front and the back of the codec.
// Uses b64sc_pkg for the entry type and depth.
module b64sc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  b64sc_pkg::rec_t wr_data,
	output logic            full,
	input  logic            rd,
	output b64sc_pkg::rec_t rd_data,
	output logic            empty
);

	b64sc_pkg::rec_t mem_q [b64sc_pkg::QDEPTH];

	logic [b64sc_pkg::QAW-1:0] wp_q;
	logic [b64sc_pkg::QAW-1:0] rp_q;
	logic [b64sc_pkg::QAW:0]   cnt_q;
	logic                      do_wr;
	logic                      do_rd;

	assign full    = (cnt_q == (b64sc_pkg::QAW+1)'(b64sc_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rp_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/b64sc_back.sv =====
// Back end of the base64 codec: expands each queue entry into result items,
// one per cycle into an output register while it is empty or popped. Uses b64sc_pkg.
module b64sc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64sc_pkg::rec_t      head,
	input  logic                 q_empty,
	output logic                 q_rd,
	output b64sc_pkg::out_item_t result,
	output logic                 empty,
	input  logic                 pop
);

	logic [b64sc_pkg::NSLOT-1:0] done_q;
	logic [b64sc_pkg::NSLOT-1:0] pres;
	logic [b64sc_pkg::NSLOT-1:0] rem;
	logic [b64sc_pkg::NSLOT-1:0] sel;
	logic                        last_sel;
	logic                        go;
	logic                        ov_q;
	b64sc_pkg::out_item_t        res_q;
	b64sc_pkg::out_item_t        res_d;

	// Mark the slots this entry fills
	always_comb begin
		pres = '0;
		for (int k = 0; k < b64sc_pkg::NDATA; k++) begin
			pres[3*k]   = head.dv[k];
			pres[3*k+1] = head.dv[k] && head.brk[k];
			pres[3*k+2] = head.dv[k] && head.brk[k];
		end
		pres[b64sc_pkg::NSLOT-1] = head.st_v;
	end

	// Pick the lowest slot not yet sent
	assign rem      = pres & ~done_q;
	assign sel      = rem & (~rem + 1'b1);
	assign last_sel = ((rem & ~sel) == '0);
	assign go       = !q_empty && (!ov_q || pop);
	assign q_rd     = go && last_sel;

	// Build the result for the chosen slot
	always_comb begin
		res_d          = '0;
		res_d.kind     = b64sc_pkg::KIND_DATA;
		res_d.run_end  = last_sel;
		for (int k = 0; k < b64sc_pkg::NDATA; k++) begin
			if (sel[3*k]) begin
				res_d.out_byte = head.db[k];
			end
			if (sel[3*k+1]) begin
				res_d.out_byte = b64sc_pkg::CHAR_CR;
			end
			if (sel[3*k+2]) begin
				res_d.out_byte = b64sc_pkg::CHAR_LF;
			end
		end
		if (sel[b64sc_pkg::NSLOT-1]) begin
			res_d.kind  = head.st_kind;
			res_d.count = head.st_count;
		end
	end

	// Hold the result until popped; track slots sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			done_q <= '0;
		end else if (go) begin
			ov_q   <= 1'b1;
			done_q <= last_sel ? '0 : (done_q | sel);
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;
	assign empty  = !ov_q;

endmodule

// ===== rtl/base64_stream_codec_unit.sv =====
// Base64 stream codec, top level. With queue and output idle, an accepted item is first
// written into the queue, then its first result is registered into the output register.
// Throughput: one item accepted per cycle while the four-entry queue has room; the back end
// sends one result per cycle while its output is empty or popped. An item gives about 1.33
// results per byte plus CR LF when encoding, at most one per character when decoding, plus status.
// Reset (arst_n low) empties queue and output, sets mode encode, line_length 76, clears state.
module base64_stream_codec_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  b64sc_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output b64sc_pkg::out_item_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);

	b64sc_pkg::cfg_t cfg_q;
	b64sc_pkg::rec_t wr_rec;
	b64sc_pkg::rec_t head;
	logic            q_wr;
	logic            q_rd;
	logic            q_full;
	logic            q_empty;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= b64sc_pkg::MODE_ENCODE;
			cfg_q.line_length <= b64sc_pkg::LINE_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				b64sc_pkg::REG_MODE:        cfg_q.mode        <= cfg_data[0];
				b64sc_pkg::REG_LINE_LENGTH: cfg_q.line_length <= cfg_data;
				default: ;
			endcase
		end
	end

	b64sc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr),
		.rec    (wr_rec)
	);

	b64sc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (wr_rec),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (head),
		.empty   (q_empty)
	);

	b64sc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

// ===== rtl/b64sc_checker.sv =====
// Port-level checks for the base64 stream codec, bound to the top level.
// Uses b64sc_pkg for result kinds.
module b64sc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input b64sc_pkg::out_item_t result
);

	// status results always close the run of their item
	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != b64sc_pkg::KIND_DATA) |-> result.run_end)
		else $error("status result without run_end");

	// status results carry no byte
	a_status_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != b64sc_pkg::KIND_DATA) |-> (result.out_byte == 8'd0))
		else $error("status result with nonzero byte");

	// only end results carry a count
	a_count_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind != b64sc_pkg::KIND_END) |-> (result.count == 16'd0))
		else $error("count outside end result");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while waiting");

endmodule

bind base64_stream_codec_unit b64sc_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
